// ===== rtl/core/sisc_pkg.sv =====
// Package for the SI prefix size scaler: widths, limits and the per-prefix
// constant tables (scan thresholds, rounding terms, divisors). No dependencies.
package sisc_pkg;

  localparam int unsigned VAL_W   = 64;
  localparam int unsigned DVS_W   = 57;   // 100 * 1000^5 < 2^57
  localparam int unsigned MM_W    = 14;   // scaled value in tenths, < 10000
  localparam int unsigned WHOLE_W = 10;
  localparam int unsigned TENTH_W = 4;
  localparam int unsigned PFX_W   = 3;
  localparam int unsigned SEL_W   = 3;

  localparam logic [VAL_W-1:0] NO_PREFIX_MAX = 64'd999;
  localparam logic [SEL_W-1:0] SEL_EXA       = 3'd5;
  localparam logic [PFX_W-1:0] PFX_NONE      = 3'd0;

  // v < 999950 * 1000^sel picks that prefix; exa takes whatever is left
  function automatic logic [VAL_W-1:0] sisc_thresh(input logic [SEL_W-1:0] sel);
    logic [VAL_W-1:0] r;
    case (sel)
      3'd0:    r = 64'd999950;
      3'd1:    r = 64'd999950000;
      3'd2:    r = 64'd999950000000;
      3'd3:    r = 64'd999950000000000;
      3'd4:    r = 64'd999950000000000000;
      default: r = '1;
    endcase
    return r;
  endfunction

  // 0.05 unit of the prefix
  function automatic logic [VAL_W-1:0] sisc_round_add(input logic [SEL_W-1:0] sel);
    logic [VAL_W-1:0] r;
    case (sel)
      3'd0:    r = 64'd50;
      3'd1:    r = 64'd50000;
      3'd2:    r = 64'd50000000;
      3'd3:    r = 64'd50000000000;
      3'd4:    r = 64'd50000000000000;
      default: r = 64'd50000000000000000;
    endcase
    return r;
  endfunction

  // largest value that still takes the rounding term: (2^63-1) - add
  function automatic logic [VAL_W-1:0] sisc_round_lim(input logic [SEL_W-1:0] sel);
    logic [VAL_W-1:0] r;
    case (sel)
      3'd0:    r = 64'd9223372036854775757;
      3'd1:    r = 64'd9223372036854725807;
      3'd2:    r = 64'd9223372036804775807;
      3'd3:    r = 64'd9223371986854775807;
      3'd4:    r = 64'd9223322036854775807;
      default: r = 64'd9173372036854775807;
    endcase
    return r;
  endfunction

  // one tenth of the prefix: 100 * 1000^sel
  function automatic logic [DVS_W-1:0] sisc_divisor(input logic [SEL_W-1:0] sel);
    logic [DVS_W-1:0] r;
    case (sel)
      3'd0:    r = 57'd100;
      3'd1:    r = 57'd100000;
      3'd2:    r = 57'd100000000;
      3'd3:    r = 57'd100000000000;
      3'd4:    r = 57'd100000000000000;
      default: r = 57'd100000000000000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/si_prefix_size_scaler_core.sv =====
// Top level of the SI prefix size scaler: sequencer, prefix scan, rounding
// and output register. Depends on sisc_pkg, sisc_div, sisc_fmt.
//
//  channel | signals                                     | dir
//  in      | in_valid_i, in_ready_o, size_value_i        | in
//  out     | out_valid_o, out_ready_i, whole_part_o,     | out
//          | tenths_digit_o, prefix_code_o               |
//
// Values up to 999 go from the scan straight to the output state; others take the prefix scan,
// a rounding step, the divide state (start, quotient bits, done) and the output state.
// in_ready_o is high only in idle; one item is in work at a time.
// A finished result waits in the output register; a new item may be taken meanwhile.
// Reset (rst_ni, async, active low) clears the sequencer and output valid.
module si_prefix_size_scaler_core import sisc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VAL_W-1:0]   size_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WHOLE_W-1:0] whole_part_o,
  output logic [TENTH_W-1:0] tenths_digit_o,
  output logic [PFX_W-1:0]   prefix_code_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROUND,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [VAL_W-1:0]   v_q;
  logic [SEL_W-1:0]   sel_q;
  logic               pass_q;
  logic               start_q;
  logic [MM_W-1:0]    mm_q;
  logic               out_valid_q;
  logic [WHOLE_W-1:0] whole_q;
  logic [TENTH_W-1:0] tenths_q;
  logic [PFX_W-1:0]   prefix_q;

  logic               div_done;
  logic [MM_W-1:0]    div_quot;
  logic [WHOLE_W-1:0] fmt_whole;
  logic [TENTH_W-1:0] fmt_tenths;
  logic               in_acc;
  logic               out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  sisc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (v_q),
    .divisor_i  (sisc_divisor(sel_q)),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  sisc_fmt u_fmt (
    .mm_i     (mm_q),
    .whole_o  (fmt_whole),
    .tenths_o (fmt_tenths)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v_q         <= '0;
      sel_q       <= '0;
      pass_q      <= 1'b0;
      start_q     <= 1'b0;
      mm_q        <= '0;
      out_valid_q <= 1'b0;
      whole_q     <= '0;
      tenths_q    <= '0;
      prefix_q    <= '0;
    end else begin
      start_q <= (state_q == ST_ROUND);
      if (out_valid_q && out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            v_q     <= size_value_i;
            sel_q   <= '0;
            pass_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (v_q <= NO_PREFIX_MAX) begin
            pass_q  <= 1'b1;
            state_q <= ST_OUT;
          end else if (sel_q == SEL_EXA || v_q < sisc_thresh(sel_q)) begin
            state_q <= ST_ROUND;
          end else begin
            sel_q <= sel_q + 1'b1;
          end
        end
        ST_ROUND: begin
          if (v_q <= sisc_round_lim(sel_q)) begin
            v_q <= v_q + sisc_round_add(sel_q);
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            mm_q    <= div_quot;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (pass_q) begin
              whole_q  <= v_q[WHOLE_W-1:0];
              tenths_q <= '0;
              prefix_q <= PFX_NONE;
            end else begin
              whole_q  <= fmt_whole;
              tenths_q <= fmt_tenths;
              prefix_q <= sel_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign whole_part_o   = whole_q;
  assign tenths_digit_o = tenths_q;
  assign prefix_code_o  = prefix_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("block ready right after taking an item");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide state");

  a_no_prefix_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prefix_code_o == PFX_NONE |-> tenths_digit_o == '0)
    else $error("unscaled result with nonzero tenths");

  a_tenths_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tenths_digit_o <= 4'd9 && prefix_code_o <= 3'd6)
    else $error("tenths digit or prefix out of range");

endmodule

// ===== rtl/core/sisc_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on sisc_pkg.
module sisc_div import sisc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VAL_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [MM_W-1:0]   quot_o
);

  localparam int unsigned CNT_W = $clog2(VAL_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [VAL_W-1:0] dvd_q;   // dividend shifts out, quotient shifts in

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             qbit;
  logic [DVS_W-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, dvd_q[VAL_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    qbit    = (shifted >= {1'b0, dvs_q});
    rem_d   = qbit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dvd_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      dvd_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[VAL_W-2:0], qbit};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[MM_W-1:0];

endmodule

// ===== rtl/core/sisc_fmt.sv =====
// Splits the scaled value in tenths into whole part and tenths digit,
// dividing by ten through a reciprocal multiply. Depends on sisc_pkg.
module sisc_fmt import sisc_pkg::*; (
  input  logic [MM_W-1:0]    mm_i,
  output logic [WHOLE_W-1:0] whole_o,
  output logic [TENTH_W-1:0] tenths_o
);

  localparam logic [MM_W-1:0] RECIP_10 = 14'd6554;  // ceil(2^16 / 10), exact below 10000

  logic [2*MM_W-1:0] prod;
  logic [MM_W-1:0]   times10;
  logic [MM_W-1:0]   rest;

  always_comb begin
    prod     = {{MM_W{1'b0}}, mm_i} * {{MM_W{1'b0}}, RECIP_10};
    whole_o  = prod[16 +: WHOLE_W];
    times10  = {1'b0, whole_o, 3'b000} + {3'b000, whole_o, 1'b0};
    rest     = mm_i - times10;
    tenths_o = rest[TENTH_W-1:0];
  end

endmodule
